// ===== hdl/msb_bit_packer_with_length_patch_assert.svh =====
// assertion macros for the msb bit packer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MSB_BIT_PACKER_WITH_LENGTH_PATCH_ASSERT_SVH
`define MSB_BIT_PACKER_WITH_LENGTH_PATCH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbp_pkg.sv =====
// shared types, constants and codes for the msb bit packer
// no dependencies
`timescale 1ns / 1ps

package mbp_pkg;

  // frame limits
  localparam int MAX_FRAME_BYTES = 8192;
  localparam int MAX_FIELD_BITS  = 32;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 13;
  localparam int KIND_W   = 2;
  localparam int TOTAL_W  = 14;
  localparam int WORD_W   = 40;
  localparam int REM_W    = 3;

  // length and header constants
  localparam int HEADER_BYTES = 3;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PATCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // patched byte positions
  localparam logic [INDEX_W-1:0] PATCH_IDX_HI = 13'd1;
  localparam logic [INDEX_W-1:0] PATCH_IDX_LO = 13'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  bit_value;
    logic [COUNT_W-1:0]  bit_count;
  } in_t;

  typedef struct packed {
    logic [7:0]         byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic [KIND_W-1:0]  kind;
    logic               last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_add;
    logic load_flush;
    logic step;
    logic step_last;
    logic emit_err;
    logic emit_p1;
    logic emit_p2;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic rem_one;
    logic full;
    logic near_full;
    logic short_frame;
    logic bits_nz;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/mbp_datapath.sv =====
// datapath of the msb bit packer: bit buffer, frame counters, output register
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  mbp_pkg::cmd_t    cmd,
  input  mbp_pkg::in_t     in_data,
  output mbp_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_ready,
  output mbp_pkg::out_t    out_data
);

  logic [mbp_pkg::WORD_W-1:0]  word_r, word_nxt;
  logic [mbp_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [2:0]                  bits_r, bits_nxt;
  logic [mbp_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [7:0]                  hsb_r, hsb_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mbp_pkg::out_t               out_r, out_nxt;

  logic [mbp_pkg::COUNT_W-1:0]   cnt_c;
  logic [2*mbp_pkg::VALUE_W-1:0] val_sh;
  logic [mbp_pkg::VALUE_W-1:0]   val_al;
  logic [mbp_pkg::WORD_W-1:0]    ins_word;
  logic [5:0]                    fill_sum;
  logic [mbp_pkg::TOTAL_W-1:0]   len;
  logic                          full;

  // count clamp and left alignment of the new bits
  assign cnt_c    = (in_data.bit_count > mbp_pkg::COUNT_W'(mbp_pkg::MAX_FIELD_BITS)) ?
                    mbp_pkg::COUNT_W'(mbp_pkg::MAX_FIELD_BITS) : in_data.bit_count;
  assign val_sh   = {{mbp_pkg::VALUE_W{1'b0}}, in_data.bit_value}
                    << (7'(mbp_pkg::VALUE_W) - {1'b0, cnt_c});
  assign val_al   = val_sh[mbp_pkg::VALUE_W-1:0];
  assign ins_word = {val_al, 8'h00} >> bits_r;
  assign fill_sum = {3'b000, bits_r} + cnt_c;

  // frame status
  assign full = (total_r >= mbp_pkg::TOTAL_W'(mbp_pkg::MAX_FRAME_BYTES));
  assign len  = total_r - mbp_pkg::TOTAL_W'(mbp_pkg::HEADER_BYTES);

  assign status.rem_zero    = (rem_r == '0);
  assign status.rem_one     = (rem_r == mbp_pkg::REM_W'(1));
  assign status.full        = full;
  assign status.near_full   = (total_r == mbp_pkg::TOTAL_W'(mbp_pkg::MAX_FRAME_BYTES - 1));
  assign status.short_frame = (total_r < mbp_pkg::TOTAL_W'(mbp_pkg::HEADER_BYTES));
  assign status.bits_nz     = (bits_r != '0);
  assign status.out_free    = !out_valid_r || out_ready;

  // buffer, counters and result selection
  always_comb begin
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    bits_nxt      = bits_r;
    total_nxt     = total_r;
    hsb_nxt       = hsb_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.clear) begin
      word_nxt  = '0;
      rem_nxt   = '0;
      bits_nxt  = '0;
      total_nxt = '0;
      hsb_nxt   = '0;
    end

    if (cmd.load_add) begin
      word_nxt = {word_r[mbp_pkg::WORD_W-1 -: 8], {(mbp_pkg::WORD_W-8){1'b0}}} | ins_word;
      rem_nxt  = fill_sum[5:3];
      bits_nxt = fill_sum[2:0];
    end

    if (cmd.load_flush) begin
      rem_nxt  = mbp_pkg::REM_W'(1);
      bits_nxt = '0;
    end

    // one completed byte leaves the top of the buffer
    if (cmd.step) begin
      word_nxt = word_r << 8;
      rem_nxt  = rem_r - mbp_pkg::REM_W'(1);
      if (!full) begin
        if (total_r == mbp_pkg::TOTAL_W'(1)) begin
          hsb_nxt = word_r[mbp_pkg::WORD_W-1 -: 8];
        end
        total_nxt          = total_r + mbp_pkg::TOTAL_W'(1);
        out_valid_nxt      = 1'b1;
        out_nxt.byte_value = word_r[mbp_pkg::WORD_W-1 -: 8];
        out_nxt.byte_index = total_r[mbp_pkg::INDEX_W-1:0];
        out_nxt.kind       = mbp_pkg::KIND_APPEND;
        out_nxt.last       = cmd.step_last;
      end
    end

    if (cmd.emit_err) begin
      out_valid_nxt      = 1'b1;
      out_nxt.byte_value = 8'h00;
      out_nxt.byte_index = total_r[mbp_pkg::INDEX_W-1:0];
      out_nxt.kind       = mbp_pkg::KIND_ERROR;
      out_nxt.last       = 1'b1;
    end

    // length high bits merged into header byte 1
    if (cmd.emit_p1) begin
      hsb_nxt            = hsb_r | {3'b000, len[12:8]};
      out_valid_nxt      = 1'b1;
      out_nxt.byte_value = hsb_r | {3'b000, len[12:8]};
      out_nxt.byte_index = mbp_pkg::PATCH_IDX_HI;
      out_nxt.kind       = mbp_pkg::KIND_PATCH;
      out_nxt.last       = 1'b0;
    end

    if (cmd.emit_p2) begin
      out_valid_nxt      = 1'b1;
      out_nxt.byte_value = len[7:0];
      out_nxt.byte_index = mbp_pkg::PATCH_IDX_LO;
      out_nxt.kind       = mbp_pkg::KIND_PATCH;
      out_nxt.last       = 1'b1;
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      rem_r       <= '0;
      bits_r      <= '0;
      total_r     <= '0;
      hsb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      word_r      <= word_nxt;
      rem_r       <= rem_nxt;
      bits_r      <= bits_nxt;
      total_r     <= total_nxt;
      hsb_r       <= hsb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/mbp_ctrl.sv =====
// controller of the msb bit packer: request decode and result sequencing
// depends on mbp_pkg
`timescale 1ns / 1ps

module mbp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mbp_pkg::OPCODE_W-1:0]  opcode,
  input  mbp_pkg::status_t              status,
  output mbp_pkg::cmd_t                 cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_STEP   = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;
  localparam logic [1:0] S_PATCH2 = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            mbp_pkg::OP_START: begin
              cmd.clear = 1'b1;
            end
            mbp_pkg::OP_ADD: begin
              cmd.load_add = 1'b1;
              fin_nxt      = 1'b0;
              state_nxt    = S_STEP;
            end
            mbp_pkg::OP_FINISH: begin
              fin_nxt = 1'b1;
              if (status.bits_nz) begin
                cmd.load_flush = 1'b1;
                state_nxt      = S_STEP;
              end else begin
                state_nxt = S_TAIL;
              end
            end
            default: ;
          endcase
        end
      end
      // drain completed bytes, dropped ones need no output slot
      S_STEP: begin
        if (status.rem_zero) begin
          state_nxt = fin_r ? S_TAIL : S_IDLE;
        end else if (status.full || status.out_free) begin
          cmd.step      = 1'b1;
          cmd.step_last = !fin_r && (status.rem_one || status.near_full);
        end
      end
      S_TAIL: begin
        if (status.out_free) begin
          if (status.short_frame) begin
            cmd.emit_err = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.emit_p1 = 1'b1;
            state_nxt   = S_PATCH2;
          end
        end
      end
      S_PATCH2: begin
        if (status.out_free) begin
          cmd.emit_p2 = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== hdl/msb_bit_packer_with_length_patch.sv =====
// Top level of the msb-first bit packer with header length patch.
// Depends on mbp_pkg, mbp_ctrl and mbp_datapath.
//
// Usage:
//  - in_valid/in_ready/in_data carry requests: start (clear frame), add
//    (append the low bit_count bits, MSB first) and finish (flush, patch).
//  - out_valid/out_ready/out_data carry result bytes with index and kind;
//    last marks the final result of a request.
//  - a request is taken only while the controller is idle; after an add the
//    controller drains N completed bytes (0 to 4) from the 40-bit bit buffer,
//    one byte per cycle unless a byte waits on a stalled receiver.
//  - a finish runs a tail check and the two patches (short frame: tail check,
//    error), after a flush byte and a drain check if a partial byte remains.
//  - a first result is registered from the drain or tail state after acceptance.
//  - the output register holds one result; the next request is accepted
//    while it waits, and byte emission pauses while the receiver stalls.
//  - bytes beyond the frame limit are dropped but still take a drain step.
//  - synchronous reset clears the frame state and the output valid.
`timescale 1ns / 1ps

module msb_bit_packer_with_length_patch (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mbp_pkg::out_t out_data
);

  mbp_pkg::cmd_t    cmd;
  mbp_pkg::status_t status;

  // request decode and sequencing
  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (in_data.opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // bit buffer, counters and output register
  mbp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/mbp_checker.sv =====
// port-level checker for the msb bit packer, bound to the top level
// depends on mbp_pkg and msb_bit_packer_with_length_patch_assert.svh
`timescale 1ns / 1ps
`include "msb_bit_packer_with_length_patch_assert.svh"

module mbp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input mbp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input mbp_pkg::out_t out_data
);

  logic kind_ok;
  logic patch_idx_ok;
  logic err_ok;

  // result field checks
  assign kind_ok      = (out_data.kind == mbp_pkg::KIND_APPEND) ||
                        (out_data.kind == mbp_pkg::KIND_PATCH) ||
                        (out_data.kind == mbp_pkg::KIND_ERROR);
  assign patch_idx_ok = (out_data.byte_index == mbp_pkg::PATCH_IDX_HI) ||
                        (out_data.byte_index == mbp_pkg::PATCH_IDX_LO);
  assign err_ok       = out_data.last && (out_data.byte_value == 8'h00) &&
                        (out_data.byte_index < mbp_pkg::INDEX_W'(mbp_pkg::HEADER_BYTES));

  // a waiting request holds
  `MBP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "request changed while waiting")

  // a stalled result holds
  `MBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // only defined kinds leave the block
  `MBP_ASSERT_NOW(a_kind_ok, out_valid, kind_ok, "undefined result kind")

  // patches only rewrite header bytes one and two
  `MBP_ASSERT_NOW(a_patch_idx, out_valid && out_data.kind == mbp_pkg::KIND_PATCH, patch_idx_ok, "patch at wrong index")

  // error result closes a short frame
  `MBP_ASSERT_NOW(a_err_form, out_valid && out_data.kind == mbp_pkg::KIND_ERROR, err_ok, "malformed error result")

endmodule

bind msb_bit_packer_with_length_patch mbp_checker u_mbp_checker (.*);
